/* design/sli_pkg.sv */
// Package for the schedule linear interpolator.
// Field widths, register indexes, breakpoint entry type, sequencer states
// and the output saturation helper. No dependencies.
`default_nettype none

package sli_pkg;

   // Field widths
   localparam int TIME_W   = 17;   // breakpoint time, unsigned Q1.16
   localparam int VAL_W    = 24;   // track value, signed Q8.16
   localparam int SCALE_W  = 24;   // step scale, unsigned Q0.24
   localparam int COUNT_W  = 5;    // breakpoint count register
   localparam int STEP_W   = 16;   // step index
   localparam int SLOT_W   = 4;    // load slot
   localparam int SEG_W    = 4;    // reported segment
   localparam int CSR_IDX_W  = 1;
   localparam int CSR_DATA_W = 24;

   // Shared multiplier operands and product
   localparam int MUL_A_W = VAL_W + 1;
   localparam int MUL_B_W = TIME_W + 1;
   localparam int PROD_W  = MUL_A_W + MUL_B_W;

   // Normalized query time: (step * scale) >> 8, kept at full width
   localparam int T_SHIFT  = 8;
   localparam int T_FULL_W = STEP_W + SCALE_W - T_SHIFT;

   // Interpolation numerator and divider
   localparam int NUM_W       = PROD_W;
   localparam int QUO_W       = VAL_W;
   localparam int DIV_STEPS   = QUO_W / 2;
   localparam int DIV_CNT_W   = $clog2(DIV_STEPS);

   localparam int DEF_MAX_POINTS = 16;

   // Register indexes
   localparam logic [CSR_IDX_W-1:0] REG_STEP_SCALE       = 1'd0;
   localparam logic [CSR_IDX_W-1:0] REG_BREAKPOINT_COUNT = 1'd1;

   localparam logic [COUNT_W-1:0] COUNT_RESET = 5'd2;

   // Input item modes
   localparam logic MODE_LOAD  = 1'b0;
   localparam logic MODE_QUERY = 1'b1;

   localparam logic STATUS_OK   = 1'b0;
   localparam logic STATUS_HELD = 1'b1;

   // One breakpoint table entry
   typedef struct packed {
      logic [TIME_W-1:0]       ptime;
      logic signed [VAL_W-1:0] gamma;
      logic signed [VAL_W-1:0] coupling;
   } point_type;

   // Sequencer states
   typedef enum logic [3:0] {
      ST_IDLE,
      ST_MUL_T,
      ST_RD0,
      ST_LEFT,
      ST_CMP,
      ST_DIFF,
      ST_MUL_A,
      ST_MUL_B,
      ST_SUM,
      ST_DIV_GO,
      ST_DIV_WAIT,
      ST_DONE
   } state_type;

   // Clamp a signed quotient to the track value range
   function automatic logic signed [VAL_W-1:0] sat_val(input logic signed [QUO_W:0] q);
      logic signed [QUO_W:0] hi;
      logic signed [QUO_W:0] lo;
      hi = (QUO_W+1)'((1 << (VAL_W - 1)) - 1);
      lo = -(QUO_W+1)'(1 << (VAL_W - 1));
      if (q > hi) begin
         sat_val = hi[VAL_W-1:0];
      end else if (q < lo) begin
         sat_val = lo[VAL_W-1:0];
      end else begin
         sat_val = q[VAL_W-1:0];
      end
   endfunction

endpackage

`default_nettype wire

/* design/sli_table.sv */
// Breakpoint table: one write port, one registered read port.
// Depends on sli_pkg for the entry type.
`default_nettype none

module sli_table #(
   parameter int DEPTH = sli_pkg::DEF_MAX_POINTS,
   parameter int AW    = $clog2(DEPTH)
) (
   input  wire logic                 clock,
   input  wire logic                 wr_en,
   input  wire logic [AW-1:0]        wr_addr,
   input  wire sli_pkg::point_type   wr_data,
   input  wire logic [AW-1:0]        rd_addr,
   output sli_pkg::point_type        rd_data
);

   sli_pkg::point_type mem [DEPTH];
   sli_pkg::point_type rd_data_ff;

   // Write on load transfers
   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[wr_addr] <= wr_data;
      end
   end

   // Registered read, every cycle
   always_ff @(posedge clock) begin
      rd_data_ff <= mem[rd_addr];
   end

   assign rd_data = rd_data_ff;

endmodule

`default_nettype wire

/* design/sli_div.sv */
// Iterative signed-by-unsigned divider, two quotient bits per cycle.
// Quotient truncates toward zero. Depends on sli_pkg for widths.
`default_nettype none

module sli_div (
   input  wire logic                                 clock,
   input  wire logic                                 reset,
   input  wire logic                                 start,
   input  wire logic signed [sli_pkg::NUM_W-1:0]     dividend,
   input  wire logic [sli_pkg::TIME_W-1:0]           divisor,
   output logic                                      done,
   output logic signed [sli_pkg::QUO_W:0]            quotient
);

   localparam int TW = sli_pkg::TIME_W;
   localparam int QW = sli_pkg::QUO_W;
   localparam int NW = sli_pkg::NUM_W;
   localparam int CW = sli_pkg::DIV_CNT_W;

   logic [TW-1:0] div_ff;
   logic [TW-1:0] rem_ff,  rem_in;
   logic [QW-1:0] low_ff,  low_in;
   logic [QW-1:0] quo_ff,  quo_in;
   logic [CW-1:0] cnt_ff;
   logic          run_ff;
   logic          done_ff;
   logic          neg_ff;

   logic [NW-1:0] mag;
   logic [TW:0]   r1, r2;
   logic          q1, q2;
   logic [TW-1:0] r1s;
   logic [QW:0]   quot_mag;

   // Magnitude of the dividend; the quotient is known to fit QW bits,
   // so the upper bits start as the partial remainder.
   always_comb begin
      mag = dividend[NW-1] ? NW'(-dividend) : NW'(dividend);
   end

   // Two restoring steps per cycle
   always_comb begin
      r1     = {rem_ff, low_ff[QW-1]};
      q1     = r1 >= {1'b0, div_ff};
      r1s    = q1 ? TW'(r1 - {1'b0, div_ff}) : r1[TW-1:0];
      r2     = {r1s, low_ff[QW-2]};
      q2     = r2 >= {1'b0, div_ff};
      rem_in = q2 ? TW'(r2 - {1'b0, div_ff}) : r2[TW-1:0];
      low_in = {low_ff[QW-3:0], 2'b00};
      quo_in = {quo_ff[QW-3:0], q1, q2};
   end

   // Control
   always_ff @(posedge clock) begin
      if (reset) begin
         run_ff  <= 1'b0;
         done_ff <= 1'b0;
         cnt_ff  <= '0;
      end else begin
         done_ff <= 1'b0;
         if (start) begin
            run_ff <= 1'b1;
            cnt_ff <= CW'(sli_pkg::DIV_STEPS - 1);
         end else if (run_ff) begin
            cnt_ff <= cnt_ff - CW'(1);
            if (cnt_ff == '0) begin
               run_ff  <= 1'b0;
               done_ff <= 1'b1;
            end
         end
      end
   end

   // Datapath
   always_ff @(posedge clock) begin
      if (start) begin
         div_ff <= divisor;
         neg_ff <= dividend[NW-1];
         rem_ff <= mag[QW +: TW];
         low_ff <= mag[QW-1:0];
         quo_ff <= '0;
      end else if (run_ff) begin
         rem_ff <= rem_in;
         low_ff <= low_in;
         quo_ff <= quo_in;
      end
   end

   assign quot_mag = {1'b0, quo_ff};
   assign quotient = neg_ff ? (QW+1)'(-quot_mag) : quot_mag;
   assign done     = done_ff;

endmodule

`default_nettype wire

/* design/schedule_linear_interpolator.sv */
// Schedule linear interpolator top level: sequencer, shared multiplier,
// breakpoint table (sli_table) and iterative divider (sli_div). Uses sli_pkg.
//
//   channel  direction  handshake            payload
//   req      in         req_valid/req_stall  mode, slot, point_*, step_index
//   rsp      out        rsp_valid/rsp_stall  gamma_value, coupling_value, segment, status
//   csr      in         csr_write            csr_index, csr_data
//
// A load is written straight into the table. A query scales the step, reads the
// first breakpoint and compares one segment per cycle; a match adds a step for the
// differences and, per track, two multiplier passes, one add, the divide start and
// a wait on the 12-step divider, or no divide on a zero-width segment. The query
// time is set by the divider and the one-segment-per-cycle table read.
// Reset is synchronous, active high; the table is not cleared.
// A stalled result sits in the output register; the next query waits at
// its end until that register is free, and no request is taken meanwhile.
`default_nettype none

module schedule_linear_interpolator #(
   parameter int MAX_POINTS = sli_pkg::DEF_MAX_POINTS
) (
   input  wire logic                                     clock,
   input  wire logic                                     reset,
   // request channel
   input  wire logic                                     req_valid,
   output logic                                          req_stall,
   input  wire logic                                     req_mode,
   input  wire logic [sli_pkg::SLOT_W-1:0]               req_slot,
   input  wire logic [sli_pkg::TIME_W-1:0]               req_point_time,
   input  wire logic signed [sli_pkg::VAL_W-1:0]         req_point_gamma,
   input  wire logic signed [sli_pkg::VAL_W-1:0]         req_point_coupling,
   input  wire logic [sli_pkg::STEP_W-1:0]               req_step_index,
   // response channel
   output logic                                          rsp_valid,
   input  wire logic                                     rsp_stall,
   output logic signed [sli_pkg::VAL_W-1:0]              rsp_gamma_value,
   output logic signed [sli_pkg::VAL_W-1:0]              rsp_coupling_value,
   output logic [sli_pkg::SEG_W-1:0]                     rsp_segment,
   output logic                                          rsp_status,
   // configuration
   input  wire logic                                     csr_write,
   input  wire logic [sli_pkg::CSR_IDX_W-1:0]            csr_index,
   input  wire logic [sli_pkg::CSR_DATA_W-1:0]           csr_data
);

   localparam int AW   = $clog2(MAX_POINTS);
   localparam int CNTW = $clog2(MAX_POINTS + 1);
   localparam int IW   = CNTW + 1;
   localparam int TW   = sli_pkg::TIME_W;
   localparam int VW   = sli_pkg::VAL_W;
   localparam int TFW  = sli_pkg::T_FULL_W;

   // Configuration registers
   logic [sli_pkg::SCALE_W-1:0] step_scale_ff;
   logic [sli_pkg::COUNT_W-1:0] count_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         step_scale_ff <= '0;
         count_ff      <= sli_pkg::COUNT_RESET;
      end else if (csr_write) begin
         unique case (csr_index)
            sli_pkg::REG_STEP_SCALE:       step_scale_ff <= csr_data[sli_pkg::SCALE_W-1:0];
            sli_pkg::REG_BREAKPOINT_COUNT: count_ff      <= csr_data[sli_pkg::COUNT_W-1:0];
            default: ;
         endcase
      end
   end

   // State and datapath registers
   sli_pkg::state_type state_ff, state_in;

   logic [sli_pkg::STEP_W-1:0]          step_ff;
   logic signed [sli_pkg::PROD_W-1:0]   prod_ff;
   logic signed [sli_pkg::PROD_W-1:0]   acc_ff;
   logic signed [sli_pkg::NUM_W-1:0]    num_ff;
   logic [TFW-1:0]                      t_ff;
   sli_pkg::point_type                  left_ff;
   sli_pkg::point_type                  right_ff;
   logic [AW-1:0]                       idx_ff;
   logic [TW-1:0]                       dr_ff, dl_ff, w_ff;
   logic                                trk_ff;
   logic                                found_ff;
   logic signed [VW-1:0]                res_g_ff, res_c_ff;
   logic signed [VW-1:0]                held_g_ff, held_c_ff;

   logic                                rsp_valid_ff;
   logic signed [VW-1:0]                rsp_gamma_ff, rsp_coupling_ff;
   logic [sli_pkg::SEG_W-1:0]           rsp_segment_ff;
   logic                                rsp_status_ff;

   // Table and divider hookup
   logic                  tbl_wr_en;
   logic [AW-1:0]         tbl_wr_addr;
   sli_pkg::point_type    tbl_wr_data;
   logic [AW-1:0]         tbl_rd_addr;
   sli_pkg::point_type    tbl_rd_data;

   logic                               div_start;
   logic                               div_done;
   logic signed [sli_pkg::QUO_W:0]     div_quot;

   // Shared multiplier operands
   logic signed [sli_pkg::MUL_A_W-1:0] mul_a;
   logic signed [sli_pkg::MUL_B_W-1:0] mul_b;

   // Misc decode
   logic                 req_xfer;
   logic                 load_xfer;
   logic                 query_xfer;
   logic [CNTW-1:0]      limit;
   logic                 first_ok;
   logic                 next_ok;
   logic                 in_seg;
   logic                 w_zero;
   logic                 out_free;
   logic signed [VW-1:0] v0, v1;
   logic signed [VW-1:0] track_val;

   assign req_xfer   = req_valid && !req_stall;
   assign load_xfer  = req_xfer && (req_mode == sli_pkg::MODE_LOAD);
   assign query_xfer = req_xfer && (req_mode == sli_pkg::MODE_QUERY);

   // Active breakpoints and segment range checks
   always_comb begin
      limit    = (32'(count_ff) > MAX_POINTS) ? CNTW'(MAX_POINTS) : CNTW'(count_ff);
      first_ok = IW'(limit) >= IW'(2);
      next_ok  = (IW'(idx_ff) + IW'(3)) <= IW'(limit);
      in_seg   = (t_ff >= TFW'(left_ff.ptime)) && (t_ff <= TFW'(tbl_rd_data.ptime));
      w_zero   = (w_ff == '0);
      out_free = !rsp_valid_ff || !rsp_stall;
      v0       = trk_ff ? left_ff.coupling  : left_ff.gamma;
      v1       = trk_ff ? right_ff.coupling : right_ff.gamma;
      track_val = w_zero ? v0 : sli_pkg::sat_val(div_quot);
   end

   // Table write on load transfers; slots past the table are dropped
   assign tbl_wr_en        = load_xfer && (32'(req_slot) < MAX_POINTS);
   assign tbl_wr_addr      = AW'(req_slot);
   assign tbl_wr_data.ptime    = req_point_time;
   assign tbl_wr_data.gamma    = req_point_gamma;
   assign tbl_wr_data.coupling = req_point_coupling;

   sli_table #(
      .DEPTH (MAX_POINTS),
      .AW    (AW)
   ) u_table (
      .clock   (clock),
      .wr_en   (tbl_wr_en),
      .wr_addr (tbl_wr_addr),
      .wr_data (tbl_wr_data),
      .rd_addr (tbl_rd_addr),
      .rd_data (tbl_rd_data)
   );

   sli_div u_div (
      .clock    (clock),
      .reset    (reset),
      .start    (div_start),
      .dividend (num_ff),
      .divisor  (w_ff),
      .done     (div_done),
      .quotient (div_quot)
   );

   // Next state
   always_comb begin
      state_in = state_ff;
      unique case (state_ff)
         sli_pkg::ST_IDLE:     if (query_xfer) state_in = sli_pkg::ST_MUL_T;
         sli_pkg::ST_MUL_T:    state_in = sli_pkg::ST_RD0;
         sli_pkg::ST_RD0:      state_in = sli_pkg::ST_LEFT;
         sli_pkg::ST_LEFT:     state_in = first_ok ? sli_pkg::ST_CMP : sli_pkg::ST_DONE;
         sli_pkg::ST_CMP: begin
            if (in_seg) begin
               state_in = sli_pkg::ST_DIFF;
            end else if (!next_ok) begin
               state_in = sli_pkg::ST_DONE;
            end
         end
         sli_pkg::ST_DIFF:     state_in = sli_pkg::ST_MUL_A;
         sli_pkg::ST_MUL_A:    state_in = sli_pkg::ST_MUL_B;
         sli_pkg::ST_MUL_B:    state_in = sli_pkg::ST_SUM;
         sli_pkg::ST_SUM:      state_in = sli_pkg::ST_DIV_GO;
         sli_pkg::ST_DIV_GO: begin
            if (!w_zero) begin
               state_in = sli_pkg::ST_DIV_WAIT;
            end else begin
               state_in = trk_ff ? sli_pkg::ST_DONE : sli_pkg::ST_MUL_A;
            end
         end
         sli_pkg::ST_DIV_WAIT: begin
            if (div_done) begin
               state_in = trk_ff ? sli_pkg::ST_DONE : sli_pkg::ST_MUL_A;
            end
         end
         sli_pkg::ST_DONE:     if (out_free) state_in = sli_pkg::ST_IDLE;
         default:              state_in = sli_pkg::ST_IDLE;
      endcase
   end

   // Sequencer outputs: stall, table read address, multiplier operands, divide start
   always_comb begin
      req_stall   = (state_ff != sli_pkg::ST_IDLE);
      tbl_rd_addr = '0;
      mul_a       = '0;
      mul_b       = '0;
      div_start   = 1'b0;
      unique case (state_ff)
         sli_pkg::ST_LEFT:  tbl_rd_addr = AW'(1);
         sli_pkg::ST_CMP:   tbl_rd_addr = AW'(IW'(idx_ff) + IW'(2));
         sli_pkg::ST_MUL_T: begin
            mul_a = sli_pkg::MUL_A_W'({1'b0, step_scale_ff});
            mul_b = sli_pkg::MUL_B_W'(step_ff);
         end
         sli_pkg::ST_MUL_A: begin
            mul_a = sli_pkg::MUL_A_W'(v0);
            mul_b = sli_pkg::MUL_B_W'(dr_ff);
         end
         sli_pkg::ST_MUL_B: begin
            mul_a = sli_pkg::MUL_A_W'(v1);
            mul_b = sli_pkg::MUL_B_W'(dl_ff);
         end
         sli_pkg::ST_DIV_GO: div_start = !w_zero;
         default: ;
      endcase
   end

   // Control registers
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= sli_pkg::ST_IDLE;
         rsp_valid_ff <= 1'b0;
         held_g_ff    <= '0;
         held_c_ff    <= '0;
         found_ff     <= 1'b0;
         trk_ff       <= 1'b0;
      end else begin
         state_ff <= state_in;
         if (query_xfer) begin
            found_ff <= 1'b0;
            trk_ff   <= 1'b0;
         end
         if (state_ff == sli_pkg::ST_CMP && in_seg) begin
            found_ff <= 1'b1;
         end
         if ((state_ff == sli_pkg::ST_DIV_GO && w_zero) ||
             (state_ff == sli_pkg::ST_DIV_WAIT && div_done)) begin
            trk_ff <= 1'b1;
         end
         // Result register: load at the end of a query, clear on transfer
         if (state_ff == sli_pkg::ST_DONE && out_free) begin
            rsp_valid_ff <= 1'b1;
            if (found_ff) begin
               held_g_ff <= res_g_ff;
               held_c_ff <= res_c_ff;
            end
         end else if (!rsp_stall) begin
            rsp_valid_ff <= 1'b0;
         end
      end
   end

   // Datapath registers
   always_ff @(posedge clock) begin
      if (query_xfer) begin
         step_ff <= req_step_index;
      end
      unique case (state_ff) inside
         sli_pkg::ST_MUL_T: prod_ff <= sli_pkg::PROD_W'(mul_a * mul_b);
         sli_pkg::ST_RD0:   t_ff    <= prod_ff[sli_pkg::T_SHIFT +: TFW];
         sli_pkg::ST_LEFT: begin
            left_ff <= tbl_rd_data;
            idx_ff  <= '0;
         end
         sli_pkg::ST_CMP: begin
            // Match keeps the right point; otherwise slide one segment on
            if (in_seg) begin
               right_ff <= tbl_rd_data;
            end else begin
               left_ff <= tbl_rd_data;
               idx_ff  <= AW'(IW'(idx_ff) + IW'(1));
            end
         end
         sli_pkg::ST_DIFF: begin
            dr_ff <= TW'(right_ff.ptime - t_ff[TW-1:0]);
            dl_ff <= TW'(t_ff[TW-1:0] - left_ff.ptime);
            w_ff  <= TW'(right_ff.ptime - left_ff.ptime);
         end
         sli_pkg::ST_MUL_A: prod_ff <= sli_pkg::PROD_W'(mul_a * mul_b);
         sli_pkg::ST_MUL_B: begin
            acc_ff  <= prod_ff;
            prod_ff <= sli_pkg::PROD_W'(mul_a * mul_b);
         end
         sli_pkg::ST_SUM:   num_ff <= sli_pkg::NUM_W'(acc_ff + prod_ff);
         sli_pkg::ST_DIV_GO, sli_pkg::ST_DIV_WAIT: begin
            if ((state_ff == sli_pkg::ST_DIV_GO && w_zero) || div_done) begin
               if (trk_ff) begin
                  res_c_ff <= track_val;
               end else begin
                  res_g_ff <= track_val;
               end
            end
         end
         sli_pkg::ST_DONE: begin
            if (out_free) begin
               rsp_gamma_ff    <= found_ff ? res_g_ff : held_g_ff;
               rsp_coupling_ff <= found_ff ? res_c_ff : held_c_ff;
               rsp_segment_ff  <= found_ff ? sli_pkg::SEG_W'(idx_ff) : '0;
               rsp_status_ff   <= found_ff ? sli_pkg::STATUS_OK : sli_pkg::STATUS_HELD;
            end
         end
         default: ;
      endcase
   end

   assign rsp_valid          = rsp_valid_ff;
   assign rsp_gamma_value    = rsp_gamma_ff;
   assign rsp_coupling_value = rsp_coupling_ff;
   assign rsp_segment        = rsp_segment_ff;
   assign rsp_status         = rsp_status_ff;

endmodule

`default_nettype wire

/* bench/interp_checker.sv */
// Checker for the schedule linear interpolator: watches the request, result
// and register ports, predicts each query result and compares field by field.
// Depends on sli_pkg for widths, register indexes and the breakpoint type.
`timescale 1ns / 100ps

module interp_checker
   import sli_pkg::*;
#(
   parameter int MAX_POINTS = DEF_MAX_POINTS
) (
   input  logic                       clock,
   input  logic                       reset,
   input  logic                       req_valid,
   input  logic                       req_stall,
   input  logic                       req_mode,
   input  logic [SLOT_W-1:0]          req_slot,
   input  logic [TIME_W-1:0]          req_point_time,
   input  logic signed [VAL_W-1:0]    req_point_gamma,
   input  logic signed [VAL_W-1:0]    req_point_coupling,
   input  logic [STEP_W-1:0]          req_step_index,
   input  logic                       rsp_valid,
   input  logic                       rsp_stall,
   input  logic signed [VAL_W-1:0]    rsp_gamma_value,
   input  logic signed [VAL_W-1:0]    rsp_coupling_value,
   input  logic [SEG_W-1:0]           rsp_segment,
   input  logic                       rsp_status,
   input  logic                       csr_write,
   input  logic [CSR_IDX_W-1:0]       csr_index,
   input  logic [CSR_DATA_W-1:0]      csr_data,
   output int                         fail_count,
   output int                         pending_count
);

   typedef struct packed {
      logic signed [VAL_W-1:0] gamma;
      logic signed [VAL_W-1:0] coupling;
      logic [SEG_W-1:0]        segment;
      logic                    status;
   } interp_result_type;

   // Predictor state: breakpoint table, held track values, registers
   point_type               breakpoints [MAX_POINTS];
   logic signed [VAL_W-1:0] held_gamma;
   logic signed [VAL_W-1:0] held_coupling;
   logic [SCALE_W-1:0]      step_scale;
   logic [COUNT_W-1:0]      point_count;

   interp_result_type       predicted_results [$];
   int                      mismatches = 0;

   // One track: weighted sum over the segment width, truncated toward zero, clamped
   function automatic logic signed [VAL_W-1:0] blend(input longint t, input longint t0,
                                                     input longint t1,
                                                     input logic signed [VAL_W-1:0] v0,
                                                     input logic signed [VAL_W-1:0] v1);
      longint span;
      longint num;
      longint quo;
      span = t1 - t0;
      if (span == 0) return v0;
      num = longint'(v0) * (t1 - t) + longint'(v1) * (t - t0);
      quo = num / span;
      if (quo > 64'sd8388607) quo = 64'sd8388607;
      else if (quo < -64'sd8388608) quo = -64'sd8388608;
      return quo[VAL_W-1:0];
   endfunction

   // Scale the step to a time, take the first segment holding it, else hold
   function automatic interp_result_type interpolate_step(input logic [STEP_W-1:0] step);
      interp_result_type r;
      logic [63:0]       t;
      int                used;
      bit                found;
      t = (64'(step) * 64'(step_scale)) >> T_SHIFT;
      used = (point_count > MAX_POINTS) ? MAX_POINTS : int'(point_count);
      found = 1'b0;
      r.gamma = held_gamma;
      r.coupling = held_coupling;
      r.segment = '0;
      r.status = STATUS_HELD;
      for (int i = 0; i + 1 < used; i++) begin
         if (!found && t >= 64'(breakpoints[i].ptime) && t <= 64'(breakpoints[i+1].ptime)) begin
            found = 1'b1;
            r.gamma = blend(longint'(t), longint'(breakpoints[i].ptime),
                            longint'(breakpoints[i+1].ptime),
                            breakpoints[i].gamma, breakpoints[i+1].gamma);
            r.coupling = blend(longint'(t), longint'(breakpoints[i].ptime),
                               longint'(breakpoints[i+1].ptime),
                               breakpoints[i].coupling, breakpoints[i+1].coupling);
            r.segment = SEG_W'(i);
            r.status = STATUS_OK;
         end
      end
      return r;
   endfunction

   task automatic check_field(input string label, input logic [31:0] want_v,
                              input logic [31:0] got_v);
      if (want_v !== got_v) begin
         $display("%0t: %s mismatch, expected %h, actual %h", $time, label, want_v, got_v);
         mismatches++;
      end
   endtask

   always @(posedge clock) begin : monitor
      interp_result_type want;
      if (reset) begin
         held_gamma = '0;
         held_coupling = '0;
         step_scale = '0;
         point_count = COUNT_RESET;
         predicted_results.delete();
      end else begin
         // result transfer: compare with the oldest prediction
         if (rsp_valid && !rsp_stall) begin
            if (predicted_results.size() == 0) begin
               $display("%0t: unexpected result, expected none, actual %h %h %h %h", $time,
                        rsp_gamma_value, rsp_coupling_value, rsp_segment, rsp_status);
               mismatches++;
            end else begin
               want = predicted_results.pop_front();
               check_field("gamma_value", 32'(want.gamma), 32'(rsp_gamma_value));
               check_field("coupling_value", 32'(want.coupling), 32'(rsp_coupling_value));
               check_field("segment", 32'(want.segment), 32'(rsp_segment));
               check_field("status", 32'(want.status), 32'(rsp_status));
            end
         end
         // request transfer: loads update the table, queries are predicted
         if (req_valid && !req_stall) begin
            if (req_mode == MODE_QUERY) begin
               want = interpolate_step(req_step_index);
               if (want.status == STATUS_OK) begin
                  held_gamma = want.gamma;
                  held_coupling = want.coupling;
               end
               predicted_results.insert(predicted_results.size(), want);
            end else if (req_slot < MAX_POINTS) begin
               breakpoints[req_slot] = '{req_point_time, req_point_gamma, req_point_coupling};
            end
         end
         if (csr_write) begin
            case (csr_index)
               REG_STEP_SCALE:       step_scale = csr_data[SCALE_W-1:0];
               REG_BREAKPOINT_COUNT: point_count = csr_data[COUNT_W-1:0];
               default: ;
            endcase
         end
      end
      fail_count <= mismatches;
      pending_count <= predicted_results.size();
   end

endmodule

/* bench/testbench.sv */
// Top of the interpolator testbench: clock, reset, request and stall stimulus,
// register writes and the verdict. Depends on sli_pkg, the block and interp_checker.
`timescale 1ns / 100ps

module testbench;
   import sli_pkg::*;

   localparam logic signed [VAL_W-1:0] VAL_MAX = 24'sh7FFFFF;
   localparam logic signed [VAL_W-1:0] VAL_MIN = 24'sh800000;
   localparam logic [TIME_W-1:0]       PTIME_TOP = 17'h1FFFF;

   logic                    clock = 1'b0;
   logic                    reset = 1'b1;
   logic                    req_valid = 1'b0;
   logic                    req_stall;
   logic                    req_mode = MODE_LOAD;
   logic [SLOT_W-1:0]       req_slot = '0;
   logic [TIME_W-1:0]       req_point_time = '0;
   logic signed [VAL_W-1:0] req_point_gamma = '0;
   logic signed [VAL_W-1:0] req_point_coupling = '0;
   logic [STEP_W-1:0]       req_step_index = '0;
   logic                    rsp_valid;
   logic                    rsp_stall = 1'b0;
   logic signed [VAL_W-1:0] rsp_gamma_value;
   logic signed [VAL_W-1:0] rsp_coupling_value;
   logic [SEG_W-1:0]        rsp_segment;
   logic                    rsp_status;
   logic                    csr_write = 1'b0;
   logic [CSR_IDX_W-1:0]    csr_index = '0;
   logic [CSR_DATA_W-1:0]   csr_data = '0;
   int                      fail_count;
   int                      pending_count;

   // Stimulus-side view of the table, used to aim queries and to bound reloads
   logic [TIME_W-1:0]  slot_times [16];
   logic [SCALE_W-1:0] cur_scale = '0;
   bit                 table_ordered = 1'b1;
   int                 burst_left = 0;

   // Directed table: zero-width segments, exact ends of the time range
   logic [TIME_W-1:0] corner_times [16] = '{17'd0, 17'd0, 17'd1, 17'd256, 17'd4096,
                                            17'd4096, 17'd20000, 17'd40000, 17'd65535,
                                            17'd65536, 17'd80000, 17'd100000, 17'd110000,
                                            17'd120000, 17'd131070, 17'd131071};

   always #10 clock = ~clock;

   schedule_linear_interpolator dut (
      .clock              (clock),
      .reset              (reset),
      .req_valid          (req_valid),
      .req_stall          (req_stall),
      .req_mode           (req_mode),
      .req_slot           (req_slot),
      .req_point_time     (req_point_time),
      .req_point_gamma    (req_point_gamma),
      .req_point_coupling (req_point_coupling),
      .req_step_index     (req_step_index),
      .rsp_valid          (rsp_valid),
      .rsp_stall          (rsp_stall),
      .rsp_gamma_value    (rsp_gamma_value),
      .rsp_coupling_value (rsp_coupling_value),
      .rsp_segment        (rsp_segment),
      .rsp_status         (rsp_status),
      .csr_write          (csr_write),
      .csr_index          (csr_index),
      .csr_data           (csr_data)
   );

   interp_checker u_checker (
      .clock              (clock),
      .reset              (reset),
      .req_valid          (req_valid),
      .req_stall          (req_stall),
      .req_mode           (req_mode),
      .req_slot           (req_slot),
      .req_point_time     (req_point_time),
      .req_point_gamma    (req_point_gamma),
      .req_point_coupling (req_point_coupling),
      .req_step_index     (req_step_index),
      .rsp_valid          (rsp_valid),
      .rsp_stall          (rsp_stall),
      .rsp_gamma_value    (rsp_gamma_value),
      .rsp_coupling_value (rsp_coupling_value),
      .rsp_segment        (rsp_segment),
      .rsp_status         (rsp_status),
      .csr_write          (csr_write),
      .csr_index          (csr_index),
      .csr_data           (csr_data),
      .fail_count         (fail_count),
      .pending_count      (pending_count)
   );

   function automatic logic signed [VAL_W-1:0] rand_track();
      case ($urandom_range(0, 7))
         0: return VAL_MAX;
         1: return VAL_MIN;
         2: return '0;
         default: return VAL_W'($urandom());
      endcase
   endfunction

   // One request transfer; bursts of random length, random gaps between them
   task automatic offer(input logic mode, input logic [SLOT_W-1:0] slot,
                        input logic [TIME_W-1:0] ptime, input logic signed [VAL_W-1:0] g,
                        input logic signed [VAL_W-1:0] c, input logic [STEP_W-1:0] step);
      req_valid <= 1'b1;
      req_mode <= mode;
      req_slot <= slot;
      req_point_time <= ptime;
      req_point_gamma <= g;
      req_point_coupling <= c;
      req_step_index <= step;
      @(posedge clock);
      while (req_stall) @(posedge clock);
      if (burst_left > 0) begin
         burst_left--;
      end else begin
         req_valid <= 1'b0;
         repeat ($urandom_range(1, 12)) @(posedge clock);
         burst_left = ($urandom_range(0, 5) == 0) ? $urandom_range(40, 120)
                                                  : $urandom_range(0, 8);
      end
   endtask

   task automatic send_load(input logic [SLOT_W-1:0] slot, input logic [TIME_W-1:0] ptime,
                            input logic signed [VAL_W-1:0] g,
                            input logic signed [VAL_W-1:0] c);
      slot_times[slot] = ptime;
      offer(MODE_LOAD, slot, ptime, g, c, STEP_W'($urandom()));
   endtask

   task automatic send_query(input logic [STEP_W-1:0] step);
      offer(MODE_QUERY, SLOT_W'($urandom()), TIME_W'($urandom()), rand_track(),
            rand_track(), step);
   endtask

   // Mostly steps that land inside the table, some aimed at breakpoints, some noise
   task automatic send_query_shaped();
      logic [STEP_W-1:0] step;
      longint            reach;
      int                k;
      if (cur_scale == 0 || $urandom_range(0, 9) == 0) begin
         step = STEP_W'($urandom());
      end else if ($urandom_range(0, 3) == 0) begin
         k = $urandom_range(0, 15);
         reach = ((longint'(slot_times[k]) << T_SHIFT) / cur_scale) + $urandom_range(0, 1);
         step = (reach > 65535) ? 16'hFFFF : reach[STEP_W-1:0];
      end else begin
         reach = (longint'(131072) << T_SHIFT) / cur_scale;
         step = (reach > 65535) ? STEP_W'($urandom())
                                : STEP_W'($urandom_range(0, 32'(reach)));
      end
      send_query(step);
   endtask

   task automatic load_table();
      int acc;
      acc = $urandom_range(0, 2000);
      for (int k = 0; k < 16; k++) begin
         if (table_ordered) begin
            if (k > 0) acc += ($urandom_range(0, 7) == 0) ? 0 : $urandom_range(1, 16000);
            if (acc > 131071) acc = 131071;
            send_load(SLOT_W'(k), TIME_W'(acc), rand_track(), rand_track());
         end else begin
            send_load(SLOT_W'(k), TIME_W'($urandom()), rand_track(), rand_track());
         end
      end
   endtask

   // Rewrite one breakpoint mid-stream, keeping order where the table is ordered
   task automatic reload_slot();
      int                k;
      logic [TIME_W-1:0] lo;
      logic [TIME_W-1:0] hi;
      k = $urandom_range(0, 15);
      lo = (k > 0) ? slot_times[k-1] : '0;
      hi = (k < 15) ? slot_times[k+1] : PTIME_TOP;
      if (table_ordered && lo <= hi) send_load(SLOT_W'(k), TIME_W'($urandom_range(lo, hi)),
                                               rand_track(), rand_track());
      else send_load(SLOT_W'(k), TIME_W'($urandom()), rand_track(), rand_track());
   endtask

   task automatic write_reg(input logic [CSR_IDX_W-1:0] idx, input logic [CSR_DATA_W-1:0] data);
      if (idx == REG_STEP_SCALE) cur_scale = data[SCALE_W-1:0];
      csr_write <= 1'b1;
      csr_index <= idx;
      csr_data <= data;
      @(posedge clock);
      csr_write <= 1'b0;
      @(posedge clock);
   endtask

   task automatic write_count(input logic [COUNT_W-1:0] count);
      logic [CSR_DATA_W-1:0] data;
      data = ($urandom_range(0, 1) == 0) ? '0 : CSR_DATA_W'($urandom());
      data[COUNT_W-1:0] = count;
      write_reg(REG_BREAKPOINT_COUNT, data);
   endtask

   // Stop offering, wait for every predicted result, then let a load settle
   task automatic drain();
      req_valid <= 1'b0;
      @(posedge clock);
      while (pending_count != 0) @(posedge clock);
      repeat (64) @(posedge clock);
   endtask

   // Result side: random stall pattern, plus one long hold-off to back up the block
   initial begin : receiver
      int run_left;
      int taken;
      bit long_done;
      run_left = 0;
      taken = 0;
      long_done = 1'b0;
      while (reset) @(posedge clock);
      forever begin
         @(posedge clock);
         if (rsp_valid && !rsp_stall) taken++;
         if (!long_done && taken >= 300) begin
            long_done = 1'b1;
            rsp_stall <= 1'b1;
            run_left = 500;
         end else if (run_left > 0) begin
            run_left--;
         end else if (rsp_stall) begin
            rsp_stall <= 1'b0;
            run_left = ($urandom_range(0, 5) == 0) ? $urandom_range(100, 300)
                                                   : $urandom_range(0, 10);
         end else begin
            rsp_stall <= 1'b1;
            run_left = $urandom_range(0, 7);
         end
      end
   end

   initial begin : watchdog
      #20000000;
      $display("Testbench completed WITH ERRORS");
      $finish;
   end

   initial begin : stimulus
      logic [SCALE_W-1:0] scale;
      logic [COUNT_W-1:0] count;
      repeat (12) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      // Directed: too few breakpoints, nothing interpolated yet, so held zeros
      write_count(5'd1);
      for (int k = 0; k < 16; k++) begin
         send_load(SLOT_W'(k), corner_times[k], k[0] ? VAL_MAX : VAL_MIN,
                   k[0] ? VAL_MIN : VAL_MAX);
      end
      send_query(16'd0);
      send_query(16'hFFFF);
      drain();
      // reset count, zero-width first segment
      write_count(5'd2);
      send_query(16'd0);
      drain();
      // full scale, count above the table size; last query lands past the table
      write_reg(REG_STEP_SCALE, 24'hFFFFFF);
      write_count(5'd31);
      send_query(16'd0);
      send_query(16'd1);
      send_query(16'd2);
      send_query(16'hFFFF);
      drain();
      // smallest nonzero scale, segment end points
      write_reg(REG_STEP_SCALE, 24'd1);
      write_count(5'd16);
      send_query(16'hFFFF);
      send_query(16'd256);

      // Random phases, each with its own register setting and table
      for (int p = 0; p < 10; p++) begin
         case (p)
            0: begin scale = SCALE_W'($urandom_range(300, 900)); count = 5'd16; end
            1: begin scale = 24'hFFFFFF;                     count = 5'd2;  end
            2: begin scale = 24'd256;                        count = 5'd31; end
            3: begin scale = SCALE_W'($urandom());           count = 5'd16; end
            4: begin scale = '0;                             count = 5'd0;  end
            5: begin scale = 24'd1;                          count = 5'd17; end
            6: begin
               scale = SCALE_W'($urandom_range(128, 1024));
               count = COUNT_W'($urandom_range(3, 16));
            end
            7: begin scale = SCALE_W'($urandom_range(256, 2048)); count = 5'd16; end
            8: begin
               scale = SCALE_W'($urandom_range(2, 255));
               count = COUNT_W'($urandom_range(2, 16));
            end
            default: begin scale = SCALE_W'($urandom_range(400, 700)); count = 5'd16; end
         endcase
         drain();
         write_reg(REG_STEP_SCALE, scale);
         write_count(count);
         table_ordered = (p != 3 && p != 7);
         load_table();
         repeat (170) begin
            if ($urandom_range(0, 4) == 0) reload_slot();
            else send_query_shaped();
         end
      end

      drain();
      if (fail_count == 0 && pending_count == 0) begin
         $display("Testbench completed without errors");
      end else begin
         $display("Testbench completed WITH ERRORS");
      end
      $finish;
   end

endmodule

/* schedule_linear_interpolator.f */
design/sli_pkg.sv
design/sli_table.sv
design/sli_div.sv
design/schedule_linear_interpolator.sv
bench/interp_checker.sv
bench/testbench.sv
